>>> rtl/dpf_pkg.sv
// Shared types and constants for the duplicate-filtering packet buffer.
// Beat layouts, command codes, cell control and controller state encoding.
// No dependencies.
`default_nettype none

package dpf_pkg;

    localparam int ID_W    = 16;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 7;
    localparam int LIMIT_W = 7;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_FWD   = 2'd1,
        MODE_COUNT = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    // Input beat, first field in the lowest bits.
    typedef struct packed {
        logic [STAMP_W-1:0] range_end;
        logic [STAMP_W-1:0] range_start;
        logic [STAMP_W-1:0] stamp;
        logic [ID_W-1:0]    dst_id;
        logic [ID_W-1:0]    src_id;
    } in_beat_t;

    // Result beat, first field in the lowest bits, padded to whole bytes.
    typedef struct packed {
        logic [6:0]         pad;
        logic [CNT_W-1:0]   match_count;
        logic [STAMP_W-1:0] out_stamp;
        logic [ID_W-1:0]    out_dst;
        logic [ID_W-1:0]    out_src;
        logic               packet_valid;
        logic               accepted;
    } out_beat_t;

    localparam int IN_DATA_W  = $bits(in_beat_t);
    localparam int OUT_DATA_W = $bits(out_beat_t);

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOOK = 4'b0010,
        ST_SUM  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

`default_nettype wire

>>> rtl/dpf_cell.sv
// One slot of the packet queue: holds an entry, shifts from its upper neighbor
// and compares its entry against the current command.
// Depends on dpf_pkg.
`default_nettype none

module dpf_cell #(
    parameter int ID_BITS    = 16,
    parameter int STAMP_BITS = 32
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  dpf_pkg::cell_ctl_t     ctl,
    input  wire [ID_BITS-1:0]      key_src,
    input  wire [ID_BITS-1:0]      key_dst,
    input  wire [STAMP_BITS-1:0]   key_stamp,
    input  wire [STAMP_BITS-1:0]   range_start,
    input  wire [STAMP_BITS-1:0]   range_end,
    input  wire                    nb_valid,
    input  wire [ID_BITS-1:0]      nb_src,
    input  wire [ID_BITS-1:0]      nb_dst,
    input  wire [STAMP_BITS-1:0]   nb_stamp,
    output logic                   valid,
    output logic [ID_BITS-1:0]     src,
    output logic [ID_BITS-1:0]     dst,
    output logic [STAMP_BITS-1:0]  stamp,
    output logic                   dup_hit,
    output logic                   cnt_hit
);

    logic                  valid_reg;
    logic [ID_BITS-1:0]    src_reg;
    logic [ID_BITS-1:0]    dst_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    logic                  dup_hit_reg;
    logic                  cnt_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (ctl.shift)
        begin
            valid_reg <= nb_valid;
        end
    end

    // New entry wins over the shift when both land on this slot.
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            src_reg   <= key_src;
            dst_reg   <= key_dst;
            stamp_reg <= key_stamp;
        end
        else if (ctl.shift)
        begin
            src_reg   <= nb_src;
            dst_reg   <= nb_dst;
            stamp_reg <= nb_stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        dup_hit_reg <= valid_reg && (src_reg == key_src) && (dst_reg == key_dst)
                       && (stamp_reg == key_stamp);
        cnt_hit_reg <= valid_reg && (dst_reg == key_dst)
                       && (stamp_reg >= range_start) && (stamp_reg <= range_end);
    end

    assign valid   = valid_reg;
    assign src     = src_reg;
    assign dst     = dst_reg;
    assign stamp   = stamp_reg;
    assign dup_hit = dup_hit_reg;
    assign cnt_hit = cnt_hit_reg;

endmodule

`default_nettype wire

>>> rtl/dpf_count_tree.sv
// Registered adder tree that counts the set bits of the cells' hit vector,
// with one register level per tree level.
// No package dependencies.
`default_nettype none

module dpf_count_tree #(
    parameter int N = 64
) (
    input  wire                        clk,
    input  wire [N-1:0]                bits,
    output logic [$clog2(N):0]         count
);

    localparam int LEVELS = $clog2(N);
    localparam int P      = 1 << LEVELS;
    localparam int CW     = LEVELS + 1;

    logic [CW-1:0] leaf [P];
    logic [CW-1:0] node_reg [LEVELS][P/2];

    always_comb
    begin
        for (int k = 0; k < P; k++)
        begin
            leaf[k] = '0;
            if (k < N)
            begin
                leaf[k][0] = bits[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < P/2; k++)
        begin
            node_reg[0][k] <= leaf[2*k] + leaf[2*k+1];
        end
        for (int l = 1; l < LEVELS; l++)
        begin
            for (int k = 0; k < P/2; k++)
            begin
                if (k < (P >> (l + 1)))
                begin
                    node_reg[l][k] <= node_reg[l-1][2*k] + node_reg[l-1][2*k+1];
                end
            end
        end
    end

    assign count = node_reg[LEVELS-1][0];

endmodule

`default_nettype wire

>>> rtl/dedup_packet_fifo_with_range_count.sv
// Duplicate-filtering packet buffer with destination/time range count.
// Top level: controller, chain of queue cells and the hit count tree.
// Depends on dpf_pkg, dpf_cell and dpf_count_tree.
//
// Commands arrive on the s_ channel (kind in s_tuser) and each returns exactly
// one result beat on the m_ channel. Entries live in a row of cells, oldest in
// cell 0; a pop or an overflow drop shifts the whole row down by one cell.
// cfg_we/cfg_data write the occupancy limit (0 acts as 1, above DEPTH acts as
// DEPTH). Write it only while the block is idle.
//
// Timing: a beat is taken in IDLE, the cells compare against it in LOOK, and
// the result is registered in DONE. A count also walks the registered hit
// count tree in SUM before DONE.
// After a limit write that leaves too many entries, s_tready stays low while
// the row shifts the oldest ones out.
// Reset empties the buffer and sets the limit to 64. A stalled m_ channel
// holds the result beat; the next command is taken meanwhile, and its result
// waits in DONE until the output register frees up.
`default_nettype none

module dedup_packet_fifo_with_range_count #(
    parameter int DEPTH      = 64,
    parameter int ID_BITS    = 16,
    parameter int STAMP_BITS = 32
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire [dpf_pkg::LIMIT_W-1:0]      cfg_data,   // buffer_limit
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // src_id, dst_id, stamp, range_start, range_end
    input  wire [dpf_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire [1:0]                       s_tuser,    // mode
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // accepted, packet_valid, out_src, out_dst, out_stamp, match_count, zero pad
    output logic [dpf_pkg::OUT_DATA_W-1:0]  m_tdata
);

    localparam int OW     = $clog2(DEPTH + 1);
    localparam int IW     = $clog2(DEPTH);
    localparam int LEVELS = $clog2(DEPTH);
    localparam int CW     = LEVELS + 1;
    localparam int WCW    = $clog2(LEVELS + 1);
    localparam int LW     = dpf_pkg::LIMIT_W;
    localparam int IDW    = dpf_pkg::ID_W;
    localparam int STW    = dpf_pkg::STAMP_W;
    localparam int CNW    = dpf_pkg::CNT_W;

    dpf_pkg::state_t    state_reg, state_next;
    logic [LW-1:0]      limit_reg;
    logic [OW-1:0]      occ_reg, occ_next;
    logic [WCW-1:0]     wcnt_reg, wcnt_next;
    dpf_pkg::in_beat_t  cmd_reg;
    dpf_pkg::mode_t     mode_reg;
    logic               m_valid_reg, m_valid_next;
    dpf_pkg::out_beat_t m_data_reg, m_data_next;

    logic               in_fire;
    logic [OW-1:0]      lim;
    logic [OW+LW-1:0]   limit_ext;
    logic               over_lim;
    logic               can_emit;
    logic               do_shift;
    logic               do_load;
    logic [IW-1:0]      wpos;
    logic               dup;

    logic [ID_BITS+IDW-1:0]     src_ext, dst_ext;
    logic [STAMP_BITS+STW-1:0]  stamp_ext, lo_ext, hi_ext;
    logic [ID_BITS-1:0]         key_src, key_dst;
    logic [STAMP_BITS-1:0]      key_stamp, key_lo, key_hi;
    logic [ID_BITS+IDW-1:0]     o_src_ext, o_dst_ext;
    logic [STAMP_BITS+STW-1:0]  o_stamp_ext;
    logic [CW+CNW-1:0]          cnt_ext;

    logic                   cell_valid [DEPTH+1];
    logic [ID_BITS-1:0]     cell_src   [DEPTH+1];
    logic [ID_BITS-1:0]     cell_dst   [DEPTH+1];
    logic [STAMP_BITS-1:0]  cell_stamp [DEPTH+1];
    logic [DEPTH-1:0]       dup_hits;
    logic [DEPTH-1:0]       cnt_hits;
    logic [CW-1:0]          tree_count;
    dpf_pkg::cell_ctl_t     cell_ctl [DEPTH];

    // Command fields narrowed or widened to the stored widths.
    assign src_ext   = {{ID_BITS{1'b0}}, cmd_reg.src_id};
    assign dst_ext   = {{ID_BITS{1'b0}}, cmd_reg.dst_id};
    assign stamp_ext = {{STAMP_BITS{1'b0}}, cmd_reg.stamp};
    assign lo_ext    = {{STAMP_BITS{1'b0}}, cmd_reg.range_start};
    assign hi_ext    = {{STAMP_BITS{1'b0}}, cmd_reg.range_end};
    assign key_src   = src_ext[ID_BITS-1:0];
    assign key_dst   = dst_ext[ID_BITS-1:0];
    assign key_stamp = stamp_ext[STAMP_BITS-1:0];
    assign key_lo    = lo_ext[STAMP_BITS-1:0];
    assign key_hi    = hi_ext[STAMP_BITS-1:0];

    assign o_src_ext   = {{IDW{1'b0}}, cell_src[0]};
    assign o_dst_ext   = {{IDW{1'b0}}, cell_dst[0]};
    assign o_stamp_ext = {{STW{1'b0}}, cell_stamp[0]};
    assign cnt_ext     = {{CNW{1'b0}}, tree_count};

    // Effective limit: clamp to 1..DEPTH.
    assign limit_ext = {{OW{1'b0}}, limit_reg};
    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim = OW'(1);
        end
        else if (limit_ext > (OW+LW)'(DEPTH))
        begin
            lim = OW'(DEPTH);
        end
        else
        begin
            lim = limit_ext[OW-1:0];
        end
    end

    assign over_lim = occ_reg > lim;
    assign s_tready = (state_reg == dpf_pkg::ST_IDLE) && !over_lim;
    assign in_fire  = s_tvalid && s_tready;
    assign can_emit = !m_valid_reg || m_tready;
    assign dup      = |dup_hits;

    always_comb
    begin
        state_next   = state_reg;
        occ_next     = occ_reg;
        wcnt_next    = wcnt_reg;
        do_shift     = 1'b0;
        do_load      = 1'b0;
        wpos         = occ_reg[IW-1:0];
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            dpf_pkg::ST_IDLE:
            begin
                if (over_lim)
                begin
                    // drop the oldest entry until the new limit holds
                    do_shift = 1'b1;
                    occ_next = occ_reg - OW'(1);
                end
                else if (s_tvalid)
                begin
                    state_next = dpf_pkg::ST_LOOK;
                end
            end
            dpf_pkg::ST_LOOK:
            begin
                wcnt_next = '0;
                if (mode_reg == dpf_pkg::MODE_COUNT)
                begin
                    state_next = dpf_pkg::ST_SUM;
                end
                else
                begin
                    state_next = dpf_pkg::ST_DONE;
                end
            end
            dpf_pkg::ST_SUM:
            begin
                wcnt_next = wcnt_reg + WCW'(1);
                if (wcnt_reg == WCW'(LEVELS - 1))
                begin
                    state_next = dpf_pkg::ST_DONE;
                end
            end
            dpf_pkg::ST_DONE:
            begin
                if (can_emit)
                begin
                    state_next   = dpf_pkg::ST_IDLE;
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    case (mode_reg)
                        dpf_pkg::MODE_ADD:
                        begin
                            if (!dup)
                            begin
                                m_data_next.accepted = 1'b1;
                                do_load = 1'b1;
                                if (occ_reg >= lim)
                                begin
                                    // full: shift out the oldest, append on top
                                    do_shift = 1'b1;
                                    wpos     = IW'(occ_reg - OW'(1));
                                end
                                else
                                begin
                                    occ_next = occ_reg + OW'(1);
                                end
                            end
                        end
                        dpf_pkg::MODE_FWD:
                        begin
                            if (occ_reg != '0)
                            begin
                                m_data_next.packet_valid = 1'b1;
                                m_data_next.out_src      = o_src_ext[IDW-1:0];
                                m_data_next.out_dst      = o_dst_ext[IDW-1:0];
                                m_data_next.out_stamp    = o_stamp_ext[STW-1:0];
                                do_shift = 1'b1;
                                occ_next = occ_reg - OW'(1);
                            end
                        end
                        dpf_pkg::MODE_COUNT:
                        begin
                            m_data_next.match_count = cnt_ext[CNW-1:0];
                        end
                        default:
                        begin
                            m_data_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = dpf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dpf_pkg::ST_IDLE;
            limit_reg   <= dpf_pkg::LIMIT_RESET;
            occ_reg     <= '0;
            wcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            wcnt_reg    <= wcnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        if (in_fire)
        begin
            cmd_reg  <= dpf_pkg::in_beat_t'(s_tdata);
            mode_reg <= dpf_pkg::mode_t'(s_tuser);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Top of the row has no upper neighbor: shifts in an empty slot.
    assign cell_valid[DEPTH] = 1'b0;
    assign cell_src[DEPTH]   = '0;
    assign cell_dst[DEPTH]   = '0;
    assign cell_stamp[DEPTH] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign cell_ctl[i] = '{shift: do_shift, load: do_load && (wpos == IW'(i))};

        dpf_cell #(
            .ID_BITS    (ID_BITS),
            .STAMP_BITS (STAMP_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (cell_ctl[i]),
            .key_src     (key_src),
            .key_dst     (key_dst),
            .key_stamp   (key_stamp),
            .range_start (key_lo),
            .range_end   (key_hi),
            .nb_valid    (cell_valid[i+1]),
            .nb_src      (cell_src[i+1]),
            .nb_dst      (cell_dst[i+1]),
            .nb_stamp    (cell_stamp[i+1]),
            .valid       (cell_valid[i]),
            .src         (cell_src[i]),
            .dst         (cell_dst[i]),
            .stamp       (cell_stamp[i]),
            .dup_hit     (dup_hits[i]),
            .cnt_hit     (cnt_hits[i])
        );
    end

    dpf_count_tree #(
        .N (DEPTH)
    ) u_count_tree (
        .clk   (clk),
        .bits  (cnt_hits),
        .count (tree_count)
    );

endmodule

`default_nettype wire
